[design/allm_pkg.sv]
// shared types, codes and sizes for the array linked list manager
package allm_pkg;

	localparam int CAPACITY = 1024;
	localparam int SLOT_W   = $clog2(CAPACITY + 1);
	localparam int CNT_W    = 11;
	localparam int VAL_W    = 32;
	localparam int OP_W     = 3;
	localparam int STS_W    = 2;
	localparam int STEP_W   = 5;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [STS_W-1:0]  sts_code_t;
	typedef logic [STEP_W-1:0] step_t;

	localparam op_t OP_PUSH_HEAD = 3'd0;
	localparam op_t OP_PUSH_TAIL = 3'd1;
	localparam op_t OP_INSERT_AT = 3'd2;
	localparam op_t OP_POP_HEAD  = 3'd3;
	localparam op_t OP_POP_TAIL  = 3'd4;
	localparam op_t OP_REMOVE_AT = 3'd5;
	localparam op_t OP_READ_AT   = 3'd6;

	localparam sts_code_t ST_OK     = 2'd0;
	localparam sts_code_t ST_FULL   = 2'd1;
	localparam sts_code_t ST_EMPTY  = 2'd2;
	localparam sts_code_t ST_BADPOS = 2'd3;

	localparam step_t STP_NOP        = 5'd0;
	localparam step_t STP_CLEAR      = 5'd1;
	localparam step_t STP_LOAD       = 5'd2;
	localparam step_t STP_CHECK      = 5'd3;
	localparam step_t STP_SET_HEAD   = 5'd4;
	localparam step_t STP_SET_TAIL   = 5'd5;
	localparam step_t STP_POP_HEAD   = 5'd6;
	localparam step_t STP_POP_TAIL   = 5'd7;
	localparam step_t STP_WALK_START = 5'd8;
	localparam step_t STP_WALK_A     = 5'd9;
	localparam step_t STP_WALK_B     = 5'd10;
	localparam step_t STP_MID_RD     = 5'd11;
	localparam step_t STP_MID_TAKE   = 5'd12;
	localparam step_t STP_SEL_REM    = 5'd13;
	localparam step_t STP_VAL_RD     = 5'd14;
	localparam step_t STP_VAL_TAKE   = 5'd15;
	localparam step_t STP_I1         = 5'd16;
	localparam step_t STP_I2         = 5'd17;
	localparam step_t STP_I3         = 5'd18;
	localparam step_t STP_R1         = 5'd19;
	localparam step_t STP_R2         = 5'd20;
	localparam step_t STP_R3         = 5'd21;
	localparam step_t STP_FIN        = 5'd22;

	typedef struct packed {
		logic clear_last;
		logic fail;
		op_t  op;
		logic ins_head;
		logic ins_tail;
		logic walk_zero;
		logic walk_last;
	} dp_sts_t;

endpackage

[design/allm_datapath.sv]
// node memories, list pointers and result registers of the list manager
module allm_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  allm_pkg::step_t                    step,
	output allm_pkg::dp_sts_t                  sts,
	input  logic                               cfg_wr_en,
	input  logic [allm_pkg::CNT_W-1:0]         cfg_wr_data,
	input  logic [allm_pkg::OP_W-1:0]          operation,
	input  logic signed [allm_pkg::VAL_W-1:0]  value,
	input  logic [allm_pkg::CNT_W-1:0]         position,
	output logic [allm_pkg::STS_W-1:0]         status,
	output logic signed [allm_pkg::VAL_W-1:0]  read_value,
	output logic [allm_pkg::CNT_W-1:0]         count
);
	import allm_pkg::*;

	logic [VAL_W-1:0] val_mem [0:CAPACITY];
	slot_t            next_mem [0:CAPACITY];
	slot_t            prev_mem [0:CAPACITY];
	logic [VAL_W-1:0] val_rd_q;
	slot_t            next_rd_q, prev_rd_q;

	op_t              op_q;
	logic [VAL_W-1:0] val_q;
	cnt_t             pos_q, cap_q, count_q, rem_q;
	slot_t            head_q, tail_q, free_q, at_q, s_q, p_q, n_q, clr_q;
	logic [VAL_W-1:0] rv_q;
	sts_code_t        st_q;
	sts_code_t        out_st_q;
	logic [VAL_W-1:0] out_rv_q;
	cnt_t             out_cnt_q;

	cnt_t             cap_eff;
	logic [CNT_W:0]   cnt_p1;
	sts_code_t        chk;
	logic             grows, shrinks;

	logic             val_we, next_we, prev_we;
	slot_t            val_wa, next_wa, prev_wa;
	logic [VAL_W-1:0] val_wd;
	slot_t            next_wd, prev_wd;
	slot_t            next_ra, side_ra;

	assign cap_eff = (cap_q > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : cap_q;
	assign cnt_p1  = {1'b0, count_q} + (CNT_W+1)'(1);
	assign grows   = (op_q <= OP_INSERT_AT);
	assign shrinks = (op_q >= OP_POP_HEAD) && (op_q <= OP_READ_AT);

	always_comb begin
		if (grows && (count_q >= cap_eff)) begin
			chk = ST_FULL;
		end else if (shrinks && (count_q == '0)) begin
			chk = ST_EMPTY;
		end else if ((op_q == OP_INSERT_AT) &&
				((pos_q == '0) || ({1'b0, pos_q} > cnt_p1))) begin
			chk = ST_BADPOS;
		end else if (((op_q == OP_REMOVE_AT) || (op_q == OP_READ_AT)) &&
				((pos_q == '0) || (pos_q > count_q))) begin
			chk = ST_BADPOS;
		end else begin
			chk = ST_OK;
		end
	end

	assign sts.clear_last = (clr_q == SLOT_W'(CAPACITY));
	assign sts.fail       = (chk != ST_OK);
	assign sts.op         = op_q;
	assign sts.ins_head   = (pos_q == CNT_W'(1));
	assign sts.ins_tail   = ({1'b0, pos_q} == cnt_p1);
	assign sts.walk_zero  = (pos_q == CNT_W'(1));
	assign sts.walk_last  = (rem_q == CNT_W'(1));

	// write ports
	always_comb begin
		val_we  = 1'b0;
		val_wa  = '0;
		val_wd  = '0;
		next_we = 1'b0;
		next_wa = '0;
		next_wd = '0;
		prev_we = 1'b0;
		prev_wa = '0;
		prev_wd = '0;
		case (step)
			STP_CLEAR: begin
				next_we = 1'b1;
				next_wa = clr_q;
				next_wd = ((clr_q == '0) || (clr_q == SLOT_W'(CAPACITY))) ?
					'0 : clr_q + SLOT_W'(1);
				prev_we = 1'b1;
				prev_wa = clr_q;
			end
			STP_I2: begin
				val_we  = 1'b1;
				val_wa  = s_q;
				val_wd  = val_q;
				next_we = 1'b1;
				next_wa = s_q;
				next_wd = n_q;
				prev_we = 1'b1;
				prev_wa = s_q;
				prev_wd = p_q;
			end
			STP_I3: begin
				next_we = (p_q != '0);
				next_wa = p_q;
				next_wd = s_q;
				prev_we = (n_q != '0);
				prev_wa = n_q;
				prev_wd = s_q;
			end
			STP_R2: begin
				next_we = (prev_rd_q != '0);
				next_wa = prev_rd_q;
				next_wd = next_rd_q;
				prev_we = (next_rd_q != '0);
				prev_wa = next_rd_q;
				prev_wd = prev_rd_q;
			end
			STP_R3: begin
				next_we = 1'b1;
				next_wa = s_q;
				next_wd = free_q;
				prev_we = 1'b1;
				prev_wa = s_q;
			end
			default: begin
			end
		endcase
	end

	assign next_ra = (step == STP_WALK_B) ? next_rd_q :
		(step == STP_I1) ? free_q :
		(step == STP_R1) ? s_q : at_q;
	assign side_ra = (step == STP_R1) ? s_q : at_q;

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_wa] <= val_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		val_rd_q  <= val_mem[side_ra];
		next_rd_q <= next_mem[next_ra];
		prev_rd_q <= prev_mem[side_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CNT_W'(CAPACITY);
			head_q  <= '0;
			tail_q  <= '0;
			free_q  <= SLOT_W'(1);
			count_q <= '0;
			clr_q   <= '0;
			op_q    <= '0;
			val_q   <= '0;
			pos_q   <= '0;
			rem_q   <= '0;
			at_q    <= '0;
			s_q     <= '0;
			p_q     <= '0;
			n_q     <= '0;
			rv_q    <= '0;
			st_q    <= ST_OK;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			case (step)
				STP_CLEAR: clr_q <= clr_q + SLOT_W'(1);
				STP_LOAD: begin
					op_q  <= operation;
					val_q <= value;
					pos_q <= position;
					rv_q  <= '0;
				end
				STP_CHECK: st_q <= chk;
				STP_SET_HEAD: begin
					p_q <= '0;
					n_q <= head_q;
				end
				STP_SET_TAIL: begin
					p_q <= tail_q;
					n_q <= '0;
				end
				STP_POP_HEAD: s_q <= head_q;
				STP_POP_TAIL: s_q <= tail_q;
				STP_WALK_START: begin
					at_q  <= head_q;
					rem_q <= pos_q - CNT_W'(1);
				end
				STP_WALK_B: begin
					at_q  <= next_rd_q;
					rem_q <= rem_q - CNT_W'(1);
				end
				STP_MID_RD: n_q <= at_q;
				STP_MID_TAKE: p_q <= prev_rd_q;
				STP_SEL_REM: s_q <= at_q;
				STP_VAL_TAKE: rv_q <= val_rd_q;
				STP_I1: s_q <= free_q;
				STP_I2: free_q <= next_rd_q;
				STP_I3: begin
					if (p_q == '0) begin
						head_q <= s_q;
					end
					if (n_q == '0) begin
						tail_q <= s_q;
					end
					count_q <= count_q + CNT_W'(1);
				end
				STP_R2: begin
					if (prev_rd_q == '0) begin
						head_q <= next_rd_q;
					end
					if (next_rd_q == '0) begin
						tail_q <= prev_rd_q;
					end
					rv_q <= val_rd_q;
				end
				STP_R3: begin
					free_q  <= s_q;
					count_q <= count_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step == STP_FIN) begin
			out_st_q  <= st_q;
			out_rv_q  <= rv_q;
			out_cnt_q <= count_q;
		end
	end

	assign status     = out_st_q;
	assign read_value = out_rv_q;
	assign count      = out_cnt_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");
	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(step == STP_CHECK) |-> (((count_q == '0) == (head_q == '0)) &&
			((head_q == '0) == (tail_q == '0))))
		else $error("head, tail and count disagree");
	a_free_end: assert property (@(posedge clk) disable iff (!arst_n)
		(step == STP_CHECK) |-> ((free_q == '0) == (count_q == CNT_W'(CAPACITY))))
		else $error("free chain and count disagree");
`endif

endmodule

[design/allm_ctrl.sv]
// sequencing state machine of the list manager
module allm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  allm_pkg::dp_sts_t sts,
	output allm_pkg::step_t   step
);
	import allm_pkg::*;

	localparam logic [4:0] S_CLEAR  = 5'd0;
	localparam logic [4:0] S_READY  = 5'd1;
	localparam logic [4:0] S_CHECK  = 5'd2;
	localparam logic [4:0] S_SETH   = 5'd3;
	localparam logic [4:0] S_SETT   = 5'd4;
	localparam logic [4:0] S_POPH   = 5'd5;
	localparam logic [4:0] S_POPT   = 5'd6;
	localparam logic [4:0] S_WSTART = 5'd7;
	localparam logic [4:0] S_WA     = 5'd8;
	localparam logic [4:0] S_WB     = 5'd9;
	localparam logic [4:0] S_MID    = 5'd10;
	localparam logic [4:0] S_MIDT   = 5'd11;
	localparam logic [4:0] S_SREM   = 5'd12;
	localparam logic [4:0] S_VRD    = 5'd13;
	localparam logic [4:0] S_VTAKE  = 5'd14;
	localparam logic [4:0] S_I1     = 5'd15;
	localparam logic [4:0] S_I2     = 5'd16;
	localparam logic [4:0] S_I3     = 5'd17;
	localparam logic [4:0] S_R1     = 5'd18;
	localparam logic [4:0] S_R2     = 5'd19;
	localparam logic [4:0] S_R3     = 5'd20;
	localparam logic [4:0] S_FIN    = 5'd21;

	logic [4:0] state_q, state_nxt;
	logic [4:0] after_walk;
	logic       out_valid_q;

	assign after_walk = (sts.op == OP_INSERT_AT) ? S_MID :
		(sts.op == OP_REMOVE_AT) ? S_SREM : S_VRD;

	always_comb begin
		state_nxt = state_q;
		step      = STP_NOP;
		unique case (state_q)
			S_CLEAR: begin
				step = STP_CLEAR;
				if (sts.clear_last) begin
					state_nxt = S_READY;
				end
			end
			S_READY: begin
				if (in_valid) begin
					step      = STP_LOAD;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				step = STP_CHECK;
				if (sts.fail) begin
					state_nxt = S_FIN;
				end else begin
					unique case (sts.op)
						OP_PUSH_HEAD: state_nxt = S_SETH;
						OP_PUSH_TAIL: state_nxt = S_SETT;
						OP_INSERT_AT: state_nxt = sts.ins_tail ? S_SETT :
							sts.ins_head ? S_SETH : S_WSTART;
						OP_POP_HEAD:  state_nxt = S_POPH;
						OP_POP_TAIL:  state_nxt = S_POPT;
						OP_REMOVE_AT, OP_READ_AT: state_nxt = S_WSTART;
						default:      state_nxt = S_FIN;
					endcase
				end
			end
			S_SETH: begin
				step      = STP_SET_HEAD;
				state_nxt = S_I1;
			end
			S_SETT: begin
				step      = STP_SET_TAIL;
				state_nxt = S_I1;
			end
			S_POPH: begin
				step      = STP_POP_HEAD;
				state_nxt = S_R1;
			end
			S_POPT: begin
				step      = STP_POP_TAIL;
				state_nxt = S_R1;
			end
			S_WSTART: begin
				step      = STP_WALK_START;
				state_nxt = sts.walk_zero ? after_walk : S_WA;
			end
			S_WA: begin
				step      = STP_WALK_A;
				state_nxt = S_WB;
			end
			S_WB: begin
				step = STP_WALK_B;
				if (sts.walk_last) begin
					state_nxt = after_walk;
				end
			end
			S_MID: begin
				step      = STP_MID_RD;
				state_nxt = S_MIDT;
			end
			S_MIDT: begin
				step      = STP_MID_TAKE;
				state_nxt = S_I1;
			end
			S_SREM: begin
				step      = STP_SEL_REM;
				state_nxt = S_R1;
			end
			S_VRD: begin
				step      = STP_VAL_RD;
				state_nxt = S_VTAKE;
			end
			S_VTAKE: begin
				step      = STP_VAL_TAKE;
				state_nxt = S_FIN;
			end
			S_I1: begin
				step      = STP_I1;
				state_nxt = S_I2;
			end
			S_I2: begin
				step      = STP_I2;
				state_nxt = S_I3;
			end
			S_I3: begin
				step      = STP_I3;
				state_nxt = S_FIN;
			end
			S_R1: begin
				step      = STP_R1;
				state_nxt = S_R2;
			end
			S_R2: begin
				step      = STP_R2;
				state_nxt = S_R3;
			end
			S_R3: begin
				step      = STP_R3;
				state_nxt = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					step      = STP_FIN;
					state_nxt = S_READY;
				end
			end
			default: state_nxt = S_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (step == STP_FIN) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_READY);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && out_stall) |=> (state_q == S_FIN))
		else $error("result word overwritten while stalled");
	a_clear_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (in_stall && step == STP_CLEAR))
		else $error("item taken during clearing pass");
	a_walk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB && !sts.walk_last) |=> (state_q == S_WB))
		else $error("walk left early");
`endif

endmodule

[design/array_linked_list_manager.sv]
// top level: doubly linked list in node memories with a free chain
// push/pop at head or tail: load, check, pick the end, insert or remove steps, result word
// positional requests first walk the links from the head, one link at a time
// one request at a time; next word taken once the result is registered
// reset: clearing pass over all 1025 node slots builds the free chain, input stalled until done
module array_linked_list_manager (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [allm_pkg::CNT_W-1:0]         cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [allm_pkg::OP_W-1:0]          operation,
	input  logic signed [allm_pkg::VAL_W-1:0]  value,
	input  logic [allm_pkg::CNT_W-1:0]         position,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [allm_pkg::STS_W-1:0]         status,
	output logic signed [allm_pkg::VAL_W-1:0]  read_value,
	output logic [allm_pkg::CNT_W-1:0]         count
);
	import allm_pkg::*;

	step_t   step;
	dp_sts_t sts;

	allm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.step      (step)
	);

	allm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.operation   (operation),
		.value       (value),
		.position    (position),
		.status      (status),
		.read_value  (read_value),
		.count       (count)
	);

endmodule
